// ===== sv/blmph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blmph_pkg
// Shared widths, register indexes, op codes and reset values of the banked
// level meter with peak hold.
// ----------------------------------------------------------------------------
package blmph_pkg;

  localparam int MAX_BINS_DEF = 64;

  localparam int BIN_W   = 6;
  localparam int LVL_W   = 16;
  localparam int HOLD_W  = 11;
  localparam int EL_W    = 10;
  localparam int BCNT_W  = 7;
  localparam int DEC_W   = LVL_W + EL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [LVL_W-1:0]  SMOOTHING_RST  = 16'd0;
  localparam logic [LVL_W-1:0]  DECAY_RATE_RST = 16'd0;
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST  = 11'd1200;
  localparam logic [BCNT_W-1:0] BIN_COUNT_RST  = 7'd32;

endpackage

// ===== sv/blmph_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blmph_in_if / blmph_out_if
// Valid/ready channels of the level meter: input items and result items.
// ----------------------------------------------------------------------------
interface blmph_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [blmph_pkg::BIN_W-1:0]   bin;
  logic [blmph_pkg::LVL_W-1:0]   magnitude;
  logic [blmph_pkg::EL_W-1:0]    elapsed;

  modport source (output valid, op, bin, magnitude, elapsed, input ready);
  modport sink   (input valid, op, bin, magnitude, elapsed, output ready);
endinterface

interface blmph_out_if;
  logic                          valid;
  logic                          ready;
  logic [blmph_pkg::BIN_W-1:0]   out_bin;
  logic [blmph_pkg::LVL_W-1:0]   level;
  logic [blmph_pkg::LVL_W-1:0]   peak_level;
  logic                          holding;
  logic                          changed;
  logic                          ignored;
  logic                          last;

  modport source (output valid, out_bin, level, peak_level, holding, changed, ignored, last,
                  input ready);
  modport sink   (input valid, out_bin, level, peak_level, holding, changed, ignored, last,
                  output ready);
endinterface

// ===== sv/banked_level_meter_peak_hold_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_level_meter_peak_hold_top
// Per-bin smoothed level, held peak and hold timer, updated by magnitude
// samples and walked by time ticks.
// ----------------------------------------------------------------------------
// Timing: one item at a time. A sample for an active bin passes, from its
// transfer to the earliest next input transfer, through memory read, two passes
// through the one 17x16 multiplier and result; a sample for an inactive bin
// goes straight to the result. A tick for N active bins takes one multiplier pass
// for the decay amount, then read, update and result per bin through the
// single port of the bin memories. Stalls on the result side lengthen each of
// these sequences. The stores read as zero after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module banked_level_meter_peak_hold_top #(
  parameter int MAX_BINS = blmph_pkg::MAX_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [blmph_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [blmph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  blmph_in_if.sink                          in_item,
  blmph_out_if.source                       out_res
);
  import blmph_pkg::*;

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [BCNT_W-1:0] MAX_CNT = BCNT_W'(MAX_BINS);
  localparam int MUL_W = LVL_W + 1;
  localparam int PROD_W = MUL_W + LVL_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_RD   = 7'b0000100,
    S_MUL1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_TICK = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;

  // configuration
  logic [LVL_W-1:0]  smoothing_r;
  logic [LVL_W-1:0]  rate_r;
  logic [HOLD_W-1:0] hold_time_r;
  logic [BCNT_W-1:0] bin_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothing_r <= SMOOTHING_RST;
      rate_r      <= DECAY_RATE_RST;
      hold_time_r <= HOLD_TIME_RST;
      bin_count_r <= BIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SMOOTHING:  smoothing_r <= cfg_wdata;
        CFG_DECAY_RATE: rate_r      <= cfg_wdata;
        CFG_HOLD_TIME:  hold_time_r <= cfg_wdata[HOLD_W-1:0];
        CFG_BIN_COUNT:  bin_count_r <= cfg_wdata[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [BCNT_W-1:0] n_act;
  always_comb begin
    if (bin_count_r == '0) begin
      n_act = BCNT_W'(1);
    end else if (bin_count_r > MAX_CNT) begin
      n_act = MAX_CNT;
    end else begin
      n_act = bin_count_r;
    end
  end

  // item and working registers
  logic              op_r;
  logic [LVL_W-1:0]  mag_r;
  logic [EL_W-1:0]   el_r;
  logic [AW-1:0]     idx_r;
  logic [DEC_W-1:0]  dec_r;
  logic [PROD_W-1:0] acc_r;

  // bin memories, valid bit per entry stands in for the reset clear
  logic [LVL_W-1:0]  lvl_mem  [MAX_BINS];
  logic [LVL_W-1:0]  peak_mem [MAX_BINS];
  logic [HOLD_W-1:0] hold_mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld_r;
  logic [LVL_W-1:0]  rd_lvl_r, rd_pk_r;
  logic [HOLD_W-1:0] rd_hd_r;
  logic              rd_vld_r;

  logic [LVL_W-1:0]  lvl_old, pk_old;
  logic [HOLD_W-1:0] hd_old;
  assign lvl_old = rd_vld_r ? rd_lvl_r : '0;
  assign pk_old  = rd_vld_r ? rd_pk_r  : '0;
  assign hd_old  = rd_vld_r ? rd_hd_r  : '0;

  // shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [LVL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    case (st_r)
      S_MUL1: begin
        mul_a = {1'b0, lvl_old};
        mul_b = smoothing_r;
      end
      S_MUL2: begin
        mul_a = {1'b1, {LVL_W{1'b0}}} - {1'b0, smoothing_r};
        mul_b = mag_r;
      end
      default: begin
        mul_a = MUL_W'(el_r);
        mul_b = rate_r;
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // sample update
  logic [PROD_W-1:0] s_sum;
  logic [LVL_W-1:0]  s_lvl, s_pk;
  logic [HOLD_W-1:0] s_hd;
  logic              s_cap, s_chg;
  assign s_sum = acc_r + mul_p;
  assign s_lvl = s_sum[2*LVL_W-1:LVL_W];
  assign s_cap = (s_lvl >= pk_old);
  assign s_pk  = s_cap ? s_lvl : pk_old;
  assign s_hd  = s_cap ? hold_time_r : hd_old;
  assign s_chg = (s_lvl != lvl_old) || (s_pk != pk_old) || (s_hd != hd_old);

  // tick update
  logic [HOLD_W-1:0] el_ext, t_hd;
  logic [LVL_W-1:0]  t_pk;
  logic              t_chg, t_last;
  assign el_ext = HOLD_W'(el_r);
  assign t_hd   = (hd_old > el_ext) ? hd_old - el_ext : '0;
  always_comb begin
    if (t_hd != '0) begin
      t_pk = pk_old;
    end else if (DEC_W'(pk_old) > dec_r) begin
      t_pk = pk_old - dec_r[LVL_W-1:0];
    end else begin
      t_pk = '0;
    end
  end
  assign t_chg  = (t_hd != hd_old) || (t_pk != pk_old);
  assign t_last = ((BCNT_W'(idx_r) + BCNT_W'(1)) == n_act);

  logic wr_en;
  assign wr_en = (st_r == S_MUL2) || (st_r == S_TICK);

  always_ff @(posedge clk) begin
    if (st_r == S_RD) begin
      rd_lvl_r <= lvl_mem[idx_r];
      rd_pk_r  <= peak_mem[idx_r];
      rd_hd_r  <= hold_mem[idx_r];
    end
    if (wr_en) begin
      lvl_mem[idx_r]  <= (st_r == S_MUL2) ? s_lvl : lvl_old;
      peak_mem[idx_r] <= (st_r == S_MUL2) ? s_pk : t_pk;
      hold_mem[idx_r] <= (st_r == S_MUL2) ? s_hd : t_hd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[idx_r] <= 1'b1;
    end
  end

  // result register
  logic [BIN_W-1:0]  o_bin_r;
  logic [LVL_W-1:0]  o_lvl_r, o_pk_r;
  logic              o_hold_r, o_chg_r, o_ign_r, o_last_r;

  logic in_xfer, out_xfer, bin_ok;
  assign in_item.ready = (st_r == S_IDLE);
  assign in_xfer  = in_item.valid && in_item.ready;
  assign out_xfer = out_res.valid && out_res.ready;
  assign bin_ok   = (BCNT_W'(in_item.bin) < n_act);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_item.op == OP_TICK) begin
            st_nxt = S_DEC;
          end else if (bin_ok) begin
            st_nxt = S_RD;
          end else begin
            st_nxt = S_OUT;
          end
        end
      end
      S_DEC:  st_nxt = S_RD;
      S_RD:   st_nxt = (op_r == OP_TICK) ? S_TICK : S_MUL1;
      S_MUL1: st_nxt = S_MUL2;
      S_MUL2: st_nxt = S_OUT;
      S_TICK: st_nxt = S_OUT;
      S_OUT: begin
        if (out_xfer) begin
          st_nxt = (op_r == OP_TICK && !o_last_r) ? S_RD : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_vld_r <= vld_r[idx_r];
    case (st_r)
      S_IDLE: begin
        op_r  <= in_item.op;
        mag_r <= in_item.magnitude;
        el_r  <= in_item.elapsed;
        idx_r <= (in_item.op == OP_TICK) ? '0 : in_item.bin[AW-1:0];
        // inactive bin: answer at once, state untouched
        o_bin_r  <= in_item.bin;
        o_lvl_r  <= '0;
        o_pk_r   <= '0;
        o_hold_r <= 1'b0;
        o_chg_r  <= 1'b0;
        o_ign_r  <= 1'b1;
        o_last_r <= 1'b1;
      end
      S_DEC:  dec_r <= mul_p[DEC_W-1:0];
      S_MUL1: acc_r <= mul_p + PROD_W'(32'h8000);
      S_MUL2: begin
        o_bin_r  <= BIN_W'(idx_r);
        o_lvl_r  <= s_lvl;
        o_pk_r   <= s_pk;
        o_hold_r <= (s_hd != '0);
        o_chg_r  <= s_chg;
        o_ign_r  <= 1'b0;
        o_last_r <= 1'b1;
      end
      S_TICK: begin
        o_bin_r  <= BIN_W'(idx_r);
        o_lvl_r  <= lvl_old;
        o_pk_r   <= t_pk;
        o_hold_r <= (t_hd != '0);
        o_chg_r  <= t_chg;
        o_ign_r  <= 1'b0;
        o_last_r <= t_last;
      end
      S_OUT: begin
        if (out_xfer && op_r == OP_TICK && !o_last_r) begin
          idx_r <= idx_r + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid      = (st_r == S_OUT);
  assign out_res.out_bin    = o_bin_r;
  assign out_res.level      = o_lvl_r;
  assign out_res.peak_level = o_pk_r;
  assign out_res.holding    = o_hold_r;
  assign out_res.changed    = o_chg_r;
  assign out_res.ignored    = o_ign_r;
  assign out_res.last       = o_last_r;

endmodule
